/* src/wttmn_pkg.sv */
// Shared constants and types for the wrapping tick to monotonic ns block.
`default_nettype none
package wttmn_pkg;

  localparam int unsigned TOTAL_W = 64;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned RATE_W = 10;
  localparam int unsigned WHOLE_W = 30;
  localparam int unsigned REST_W = 10;
  localparam int unsigned MAX_STEP_W = 27;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 30;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NS_WHOLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NS_REST = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP = 2'd3;

  localparam logic [RATE_W-1:0] RST_TICK_RATE = 10'd100;
  localparam logic [WHOLE_W-1:0] RST_NS_WHOLE = 30'd10000000;
  localparam logic [REST_W-1:0] RST_NS_REST = 10'd0;
  localparam logic [MAX_STEP_W-1:0] RST_MAX_STEP = 27'd8640000;

  localparam logic OP_PRIME = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam int unsigned CNT_W = 5;
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(WHOLE_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(TOTAL_W / 2 - 1);

  typedef struct packed {
    logic start;
    logic mul_en;
    logic div_en;
    logic out_load;
  } cmd_t;

endpackage
`default_nettype wire

/* src/wttmn_ctrl.sv */
// Controller: sequences accept, multiply, divide and result load.
`default_nettype none
module wttmn_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire              out_ready,
  output wttmn_pkg::cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL = 2'd1;
  localparam logic [1:0] S_DIV = 2'd2;
  localparam logic [1:0] S_FIN = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [wttmn_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          cnt_nxt = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == wttmn_pkg::MUL_LAST) begin
          cnt_nxt = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == wttmn_pkg::DIV_LAST) begin
          cnt_nxt = '0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/wttmn_dp.sv */
// Datapath: registers, step correction, serial multiply and radix-4 divide.
`default_nettype none
module wttmn_dp (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_we,
  input  wire  [wttmn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [wttmn_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire                                  in_op,
  input  wire  signed [wttmn_pkg::SAMPLE_W-1:0] in_sample,
  input  wttmn_pkg::cmd_t                      cmd,
  output logic [wttmn_pkg::TOTAL_W-1:0]        out_monotonic_ns,
  output logic                                 out_clock_jump
);

  localparam int unsigned TW = wttmn_pkg::TOTAL_W;
  localparam int unsigned SW = wttmn_pkg::SAMPLE_W;
  localparam int unsigned RW = wttmn_pkg::RATE_W;

  logic [RW-1:0] rate_r;
  logic [wttmn_pkg::WHOLE_W-1:0] whole_r;
  logic [wttmn_pkg::REST_W-1:0] rest_r;
  logic [wttmn_pkg::MAX_STEP_W-1:0] max_step_r;

  logic [TW-1:0] total_r;
  logic [SW-1:0] prev_r;
  logic jump_r;
  logic [TW-1:0] mcand_r;
  logic [wttmn_pkg::WHOLE_W-1:0] mw_r;
  logic [wttmn_pkg::REST_W-1:0] mr_r;
  logic [TW-1:0] accw_r;
  logic [TW-1:0] accr_r;
  logic [RW-1:0] rem_r;
  logic [TW-1:0] ns_r;
  logic jump_out_r;

  logic signed [SW+1:0] diff;
  logic signed [SW+1:0] diff1;
  logic signed [SW+1:0] diff2;
  logic [SW-1:0] step;
  logic [TW-1:0] total_nxt;
  logic [RW:0] r1, r1s, r2, r2s;
  logic ge1, ge2;

  always_comb begin
    diff = $signed({{2{in_sample[SW-1]}}, in_sample})
           - $signed({{2{prev_r[SW-1]}}, prev_r});
    diff1 = diff[SW+1] ? diff + $signed((SW+2)'(64'h8000_0000)) : diff;
    diff2 = diff1[SW+1] ? diff1 + $signed((SW+2)'(64'h8000_0000)) : diff1;
    step = diff2[SW-1:0];
    total_nxt = total_r + TW'(step);
  end

  always_comb begin
    r1 = {rem_r, accr_r[TW-1]};
    ge1 = (r1 >= {1'b0, rate_r});
    r1s = ge1 ? r1 - {1'b0, rate_r} : r1;
    r2 = {r1s[RW-1:0], accr_r[TW-2]};
    ge2 = (r2 >= {1'b0, rate_r});
    r2s = ge2 ? r2 - {1'b0, rate_r} : r2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= wttmn_pkg::RST_TICK_RATE;
      whole_r <= wttmn_pkg::RST_NS_WHOLE;
      rest_r <= wttmn_pkg::RST_NS_REST;
      max_step_r <= wttmn_pkg::RST_MAX_STEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wttmn_pkg::REG_TICK_RATE: rate_r <= cfg_data[RW-1:0];
        wttmn_pkg::REG_NS_WHOLE: whole_r <= cfg_data[wttmn_pkg::WHOLE_W-1:0];
        wttmn_pkg::REG_NS_REST: rest_r <= cfg_data[wttmn_pkg::REST_W-1:0];
        wttmn_pkg::REG_MAX_STEP: max_step_r <= cfg_data[wttmn_pkg::MAX_STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      prev_r <= '0;
    end else if (cmd.start) begin
      prev_r <= in_sample;
      total_r <= (in_op == wttmn_pkg::OP_PRIME) ? '0 : total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      if (in_op == wttmn_pkg::OP_PRIME) begin
        mcand_r <= '0;
        jump_r <= 1'b0;
      end else begin
        mcand_r <= total_nxt;
        jump_r <= ({1'b0, step} > (SW+1)'(max_step_r));
      end
      mw_r <= whole_r;
      mr_r <= rest_r;
      accw_r <= '0;
      accr_r <= '0;
      rem_r <= '0;
    end else if (cmd.mul_en) begin
      if (mw_r[0]) accw_r <= accw_r + mcand_r;
      if (mr_r[0]) accr_r <= accr_r + mcand_r;
      mcand_r <= {mcand_r[TW-2:0], 1'b0};
      mw_r <= mw_r >> 1;
      mr_r <= mr_r >> 1;
    end else if (cmd.div_en) begin
      accr_r <= {accr_r[TW-3:0], ge1, ge2};
      rem_r <= r2s[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ns_r <= accw_r + ((rest_r != '0 && rate_r != '0) ? accr_r : '0);
      jump_out_r <= jump_r;
    end
  end

  assign out_monotonic_ns = ns_r;
  assign out_clock_jump = jump_out_r;

endmodule
`default_nettype wire

/* src/wrapping_tick_to_monotonic_ns.sv */
// Top level of the wrapping tick counter to monotonic nanosecond converter.
`default_nettype none
// Each request goes from acceptance to a loaded result in order through the accept step,
// a one-bit-per-cycle shift-add multiplier that forms both the whole and the remainder
// products of the tick total, a two-bit-per-cycle restoring divider by tick_rate, and
// the load of the output register, which waits while an earlier result is unread.
// One request is in work at a time; a finished result waits in the output register
// while the next request is accepted. A prime request (op 0) clears the total and
// returns 0. Configuration writes are taken at once (cfg_ready is always high).
module wrapping_tick_to_monotonic_ns (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [wttmn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [wttmn_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire                                   in_op,
  input  wire  signed [wttmn_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [wttmn_pkg::TOTAL_W-1:0]         out_monotonic_ns,
  output logic                                  out_clock_jump
);

  wttmn_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  wttmn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  wttmn_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_op            (in_op),
    .in_sample        (in_sample),
    .cmd              (cmd),
    .out_monotonic_ns (out_monotonic_ns),
    .out_clock_jump   (out_clock_jump)
  );

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in work");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result shown without a load");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.start, cmd.mul_en, cmd.div_en, cmd.out_load}))
    else $error("datapath commands overlap");

endmodule
`default_nettype wire

/* verif/wrapping_tick_to_monotonic_ns_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the wrapping tick counter to monotonic nanosecond converter.
module wrapping_tick_to_monotonic_ns_tb;

  typedef struct packed {
    logic                           op;
    logic [wttmn_pkg::SAMPLE_W-1:0] sample;
  } tick_req_t;

  typedef struct packed {
    logic [wttmn_pkg::TOTAL_W-1:0] ns;
    logic                          jump;
  } ns_result_t;

  logic                                  clk;
  logic                                  rst_n = 1'b0;
  logic                                  cfg_valid = 1'b0;
  wire                                   cfg_ready;
  logic [wttmn_pkg::CFG_IDX_W-1:0]       cfg_index = wttmn_pkg::REG_TICK_RATE;
  logic [wttmn_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
  logic                                  in_valid = 1'b0;
  wire                                   in_ready;
  logic                                  in_op = wttmn_pkg::OP_PRIME;
  logic signed [wttmn_pkg::SAMPLE_W-1:0] in_sample = '0;
  wire                                   out_valid;
  logic                                  out_ready = 1'b0;
  wire [wttmn_pkg::TOTAL_W-1:0]          out_monotonic_ns;
  wire                                   out_clock_jump;

  logic [wttmn_pkg::RATE_W-1:0]     rate_m = wttmn_pkg::RST_TICK_RATE;
  logic [wttmn_pkg::WHOLE_W-1:0]    whole_m = wttmn_pkg::RST_NS_WHOLE;
  logic [wttmn_pkg::REST_W-1:0]     rest_m = wttmn_pkg::RST_NS_REST;
  logic [wttmn_pkg::MAX_STEP_W-1:0] max_step_m = wttmn_pkg::RST_MAX_STEP;
  logic [wttmn_pkg::TOTAL_W-1:0]    tick_total_m = '0;
  logic [wttmn_pkg::SAMPLE_W-1:0]   last_sample_m = '0;

  tick_req_t  pending_reqs[$];
  ns_result_t expected_ns[$];
  logic [wttmn_pkg::SAMPLE_W-1:0] gen_prev = '0;

  int errors = 0;
  int results_checked = 0;
  int reqs_sent = 0;
  int primes_sent = 0;
  int jumps_seen = 0;
  int settings_used = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  wrapping_tick_to_monotonic_ns dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_monotonic_ns (out_monotonic_ns),
    .out_clock_jump   (out_clock_jump)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic ns_result_t advance_clock(tick_req_t r);
    logic [wttmn_pkg::TOTAL_W-1:0] step;
    ns_result_t res;
    res = '0;
    if (r.op == wttmn_pkg::OP_PRIME) begin
      last_sample_m = r.sample;
      tick_total_m = '0;
      return res;
    end
    step = {{32{r.sample[31]}}, r.sample} - {{32{last_sample_m[31]}}, last_sample_m};
    repeat (2) if (step[wttmn_pkg::TOTAL_W-1]) step = step + 64'h8000_0000;
    tick_total_m = tick_total_m + step;
    last_sample_m = r.sample;
    res.ns = tick_total_m * 64'(whole_m);
    if (rest_m != '0 && rate_m != '0)
      res.ns = res.ns + (tick_total_m * 64'(rest_m)) / 64'(rate_m);
    res.jump = step > 64'(max_step_m);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errors < 40)
      $display("mismatch on %s at %0t ns: got %0h, expected %0h", what, $time, got, want);
    errors++;
  endtask

  task automatic write_reg(input logic [wttmn_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wttmn_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      wttmn_pkg::REG_TICK_RATE: rate_m = data[wttmn_pkg::RATE_W-1:0];
      wttmn_pkg::REG_NS_WHOLE:  whole_m = data[wttmn_pkg::WHOLE_W-1:0];
      wttmn_pkg::REG_NS_REST:   rest_m = data[wttmn_pkg::REST_W-1:0];
      wttmn_pkg::REG_MAX_STEP:  max_step_m = data[wttmn_pkg::MAX_STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [wttmn_pkg::CFG_DATA_W-1:0] rate,
                               input logic [wttmn_pkg::CFG_DATA_W-1:0] whole,
                               input logic [wttmn_pkg::CFG_DATA_W-1:0] rest,
                               input logic [wttmn_pkg::CFG_DATA_W-1:0] max_step);
    write_reg(wttmn_pkg::REG_TICK_RATE, rate);
    write_reg(wttmn_pkg::REG_NS_WHOLE, whole);
    write_reg(wttmn_pkg::REG_NS_REST, rest);
    write_reg(wttmn_pkg::REG_MAX_STEP, max_step);
    settings_used++;
  endtask

  task automatic push_req(input logic op, input logic [wttmn_pkg::SAMPLE_W-1:0] sample);
    pending_reqs.push_back(tick_req_t'{op, sample});
    gen_prev = sample;
  endtask

  task automatic queue_mix(input int n);
    int left;
    int kind;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(99);
      if (kind < 5) begin
        push_req(wttmn_pkg::OP_PRIME, $urandom);
        left--;
      end else if (kind < 60) begin
        if ($urandom_range(9) == 0)
          push_req(wttmn_pkg::OP_SAMPLE, gen_prev + $urandom_range(0, 200000));
        else
          push_req(wttmn_pkg::OP_SAMPLE, gen_prev + $urandom_range(0, 2000));
        left--;
      end else if (kind < 70) begin
        push_req(wttmn_pkg::OP_SAMPLE,
                 gen_prev + 32'(max_step_m) + $urandom_range(0, 2) - 1);
        left--;
      end else if (kind < 80) begin
        push_req(wttmn_pkg::OP_SAMPLE, 32'h7FFF_FFFF - $urandom_range(0, 500));
        push_req(wttmn_pkg::OP_SAMPLE, $urandom_range(0, 500));
        left -= 2;
      end else if (kind < 88) begin
        push_req(wttmn_pkg::OP_SAMPLE, 32'h7FFF_FFFF - $urandom_range(0, 500));
        push_req(wttmn_pkg::OP_SAMPLE, 32'h8000_0000 + $urandom_range(0, 500));
        left -= 2;
      end else begin
        push_req(wttmn_pkg::OP_SAMPLE, $urandom);
        left--;
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_ns.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive
    tick_req_t next_req;
    ns_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want = advance_clock(tick_req_t'{in_op, in_sample});
        expected_ns.push_back(want);
        reqs_sent++;
        if (in_op == wttmn_pkg::OP_PRIME) primes_sent++;
        if (want.jump) jumps_seen++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_op <= next_req.op;
          in_sample <= next_req.sample;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin : watch
    ns_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_ns.size() == 0) begin
          report_mismatch("result with no request pending", out_monotonic_ns, '0);
        end else begin
          want = expected_ns.pop_front();
          results_checked++;
          if (out_monotonic_ns !== want.ns)
            report_mismatch("monotonic_ns", out_monotonic_ns, want.ns);
          if (out_clock_jump !== want.jump)
            report_mismatch("clock_jump", 64'(out_clock_jump), 64'(want.jump));
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    int unsigned rate;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    push_req(wttmn_pkg::OP_SAMPLE, 32'd1000);
    push_req(wttmn_pkg::OP_SAMPLE, 32'h7FFF_FFFF);
    push_req(wttmn_pkg::OP_SAMPLE, 32'h8000_0000);
    push_req(wttmn_pkg::OP_SAMPLE, 32'hFFFF_FFFF);
    push_req(wttmn_pkg::OP_PRIME, 32'h7FFF_FFF0);
    push_req(wttmn_pkg::OP_SAMPLE, 32'h7FFF_FFFF);
    push_req(wttmn_pkg::OP_SAMPLE, 32'd5);
    push_req(wttmn_pkg::OP_SAMPLE, 32'd5);
    push_req(wttmn_pkg::OP_SAMPLE, 32'd8640005);
    push_req(wttmn_pkg::OP_SAMPLE, 32'd17280006);
    push_req(wttmn_pkg::OP_PRIME, 32'h8000_0000);
    push_req(wttmn_pkg::OP_SAMPLE, 32'h8000_0064);
    push_req(wttmn_pkg::OP_SAMPLE, 32'd0);
    push_req(wttmn_pkg::OP_PRIME, 32'hFFFF_FFFF);
    push_req(wttmn_pkg::OP_SAMPLE, 32'h0000_0010);
    push_req(wttmn_pkg::OP_PRIME, 32'd0);
    push_req(wttmn_pkg::OP_SAMPLE, 32'd0);
    push_req(wttmn_pkg::OP_SAMPLE, 32'h5555_5555);
    push_req(wttmn_pkg::OP_SAMPLE, 32'hAAAA_AAAA);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: apply_setting(30'd1000, 30'd1000000, 30'd0, 30'd86400000);
        1: apply_setting(30'd7, 30'd142857142, 30'd6, 30'd8640000);
        2: apply_setting(30'd1, 30'd1000000000, 30'd0, 30'd0);
        3: apply_setting(30'h3FFF_FFFF, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 30'h3FFF_FFFF);
        4: apply_setting(30'd0, 30'd1000000, 30'd999, 30'd86400000);
        5: apply_setting(30'd999, 30'd1001001, 30'd1, 30'd1000);
        6: begin
          rate = $urandom_range(1, 1000);
          apply_setting(30'(rate), 30'(1000000000 / rate), 30'(1000000000 % rate),
                        30'($urandom_range(0, 86400000)));
        end
        default: apply_setting(30'h3FFF_FC01, 30'd0, 30'd1, 30'd86400000);
      endcase
      case (ph % 4)
        0: begin send_idle_pct <= 0;  stall_pct <= 0;  end
        1: begin send_idle_pct <= 64; stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  stall_pct <= 64; end
        default: begin send_idle_pct <= 36; stall_pct <= 36; end
      endcase
      queue_mix(229);
      if (ph == 0) begin
        @(posedge clk);
        hold_left <= 400;
      end
      wait_idle();
    end

    repeat (80) @(posedge clk);
    $display("sent %0d requests (%0d primes, %0d clock jumps) across %0d register settings",
             reqs_sent, primes_sent, jumps_seen, settings_used);
    $display("checked %0d results, %0d mismatches", results_checked, errors);
    if (errors == 0) begin
      $display("wrapping_tick_to_monotonic_ns verification clean");
    end else begin
      $display("wrapping_tick_to_monotonic_ns verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results still expected", expected_ns.size());
    $display("wrapping_tick_to_monotonic_ns verification failed");
    $finish;
  end

endmodule
